// ----- rtl/mtfg_pkg.sv -----
package mtfg_pkg;

	// Alert counter width; the count also stops at 16 bits
	localparam int COUNT_WIDTH = 16;

	localparam logic [15:0] TALLY_MAX = (COUNT_WIDTH >= 16) ? 16'hFFFF :
		16'((32'd1 << COUNT_WIDTH) - 32'd1);

	// MBAP header byte positions
	localparam logic [8:0] POS_TID_HI   = 9'd0;
	localparam logic [8:0] POS_TID_LO   = 9'd1;
	localparam logic [8:0] POS_PROTO_HI = 9'd2;
	localparam logic [8:0] POS_PROTO_LO = 9'd3;
	localparam logic [8:0] POS_LEN_HI   = 9'd4;
	localparam logic [8:0] POS_LEN_LO   = 9'd5;
	localparam logic [8:0] POS_UNIT     = 9'd6;
	localparam logic [8:0] POS_FUNC     = 9'd7;

	// last byte sits at LAST_OFFSET + length
	localparam logic [8:0] LAST_OFFSET  = 9'd5;
	localparam logic [7:0] PDU_LIMIT    = 8'd253;
	localparam logic [7:0] LEN_CAP      = PDU_LIMIT + 8'd1;
	localparam logic [15:0] LEN_MIN     = 16'd2;
	localparam logic [8:0] POS_MAX      = LAST_OFFSET + 9'(LEN_CAP);
	localparam logic [7:0] MAX_LEN_RESET = 8'd254;

	// function codes
	localparam logic [7:0] FC_FIRST       = 8'd1;
	localparam logic [7:0] FC_LAST_BASIC  = 8'd6;
	localparam logic [7:0] FC_WRITE_COIL  = 8'd5;
	localparam logic [7:0] FC_WRITE_REG   = 8'd6;
	localparam logic [7:0] FC_WRITE_COILS = 8'd15;
	localparam logic [7:0] FC_WRITE_REGS  = 8'd16;
	localparam logic [7:0] FC_RW_REGS     = 8'd23;

	typedef enum logic [1:0] {
		ERR_NONE,
		ERR_PROTOCOL,
		ERR_LENGTH,
		ERR_FUNCTION
	} err_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       segment_end;
	} in_item_t;

	typedef struct packed {
		logic        frame_valid;
		err_t        error_code;
		logic [15:0] xact_id;
		logic [7:0]  unit_id;
		logic [7:0]  fn_code;
		logic [7:0]  pdu_length;
		logic        is_write;
		logic        segment_done;
		logic [15:0] segment_alerts;
	} res_item_t;

endpackage

// ----- rtl/mtfg_in_stage.sv -----
module mtfg_in_stage
	import mtfg_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_item,
	input  logic     advance,
	output logic     valid_s1,
	output in_item_t item_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ----- rtl/mtfg_parser.sv -----
module mtfg_parser
	import mtfg_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic      item_valid,
	input  in_item_t  item,
	output logic      res_emit,
	output res_item_t res
);

	logic [7:0]  max_len_q;
	logic [8:0]  pos_q;
	logic [15:0] tid_q;
	logic [15:0] proto_q;
	logic [15:0] len_q;
	logic [7:0]  unit_q;
	logic [7:0]  func_q;
	logic        halted_q;
	logic [15:0] tally_q;

	logic [15:0] tid_d;
	logic [15:0] proto_d;
	logic [15:0] len_d;
	logic [7:0]  unit_d;
	logic [7:0]  func_d;
	logic [8:0]  pos_d;
	logic [15:0] tally_d;
	logic [15:0] tally_next;

	logic [7:0]  limit;
	logic [7:0]  b;
	logic [7:0]  fc_cur;
	logic [7:0]  unit_cur;
	logic        at_last;
	logic        fc_known;
	logic        fc_write;
	logic        fv;
	logic        wr;
	err_t        err;

	assign b        = item.data_byte;
	assign limit    = (max_len_q > LEN_CAP) ? LEN_CAP : max_len_q;
	assign fc_cur   = (pos_q == POS_FUNC) ? b : func_q;
	assign unit_cur = (pos_q == POS_UNIT) ? b : unit_q;
	assign at_last  = (pos_q == LAST_OFFSET + 9'(len_q[7:0]));

	assign fc_known = (fc_cur >= FC_FIRST && fc_cur <= FC_LAST_BASIC) ||
		fc_cur == FC_WRITE_COILS || fc_cur == FC_WRITE_REGS || fc_cur == FC_RW_REGS;
	assign fc_write = fc_cur == FC_WRITE_COIL || fc_cur == FC_WRITE_REG ||
		fc_cur == FC_WRITE_COILS || fc_cur == FC_WRITE_REGS || fc_cur == FC_RW_REGS;

	// header capture and checks
	always_comb begin
		tid_d   = tid_q;
		proto_d = proto_q;
		len_d   = len_q;
		unit_d  = unit_q;
		func_d  = func_q;
		err     = ERR_NONE;
		fv      = 1'b0;
		case (pos_q)
			POS_TID_HI: begin
				tid_d  = {b, 8'h00};
				func_d = 8'h00;
			end
			POS_TID_LO:   tid_d[7:0]   = b;
			POS_PROTO_HI: proto_d      = {b, 8'h00};
			POS_PROTO_LO: proto_d[7:0] = b;
			POS_LEN_HI:   len_d        = {b, 8'h00};
			POS_LEN_LO:   len_d[7:0]   = b;
			POS_UNIT: begin
				unit_d = b;
				if (proto_q != 16'h0000) begin
					err = ERR_PROTOCOL;
				end else if (len_q < LEN_MIN || len_q > {8'h00, limit}) begin
					err = ERR_LENGTH;
				end
			end
			default: begin
				func_d = fc_cur;
				if (at_last) begin
					if (!fc_known) begin
						err = ERR_FUNCTION;
					end else begin
						fv = 1'b1;
					end
				end
			end
		endcase
	end

	// result, tally and position
	always_comb begin
		wr         = fv && fc_write;
		tally_next = (wr && tally_q < TALLY_MAX) ? tally_q + 16'd1 : tally_q;
		tally_d    = (item.segment_end && err == ERR_NONE) ? 16'h0000 : tally_next;
		if (err != ERR_NONE) begin
			pos_d = pos_q;
		end else if (fv) begin
			pos_d = POS_TID_HI;
		end else begin
			pos_d = pos_q + 9'd1;
		end

		res_emit           = !halted_q && (fv || err != ERR_NONE || item.segment_end);
		res.frame_valid    = fv;
		res.error_code     = err;
		res.is_write       = wr;
		res.segment_done   = item.segment_end;
		res.segment_alerts = tally_next;
		if (fv || err != ERR_NONE) begin
			res.xact_id = tid_q;
			res.unit_id = unit_cur;
		end else begin
			res.xact_id = 16'h0000;
			res.unit_id = 8'h00;
		end
		if (fv || err == ERR_FUNCTION) begin
			res.fn_code    = fc_cur;
			res.pdu_length = len_q[7:0] - 8'd1;
		end else begin
			res.fn_code    = 8'h00;
			res.pdu_length = 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
			pos_q     <= POS_TID_HI;
			tid_q     <= 16'h0000;
			proto_q   <= 16'h0000;
			len_q     <= 16'h0000;
			unit_q    <= 8'h00;
			func_q    <= 8'h00;
			halted_q  <= 1'b0;
			tally_q   <= 16'h0000;
		end else begin
			if (cfg_we) begin
				max_len_q <= cfg_wdata;
			end
			if (item_valid && !halted_q) begin
				pos_q    <= pos_d;
				tid_q    <= tid_d;
				proto_q  <= proto_d;
				len_q    <= len_d;
				unit_q   <= unit_d;
				func_q   <= func_d;
				tally_q  <= tally_d;
				halted_q <= (err != ERR_NONE);
			end
		end
	end

	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> !res_emit)
		else $error("result while halted");

	a_err_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !halted_q && err != ERR_NONE) |=> halted_q)
		else $error("error did not halt");

	a_frame_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		fv |-> (err == ERR_NONE && pos_q >= POS_FUNC))
		else $error("frame flagged with error or inside header");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_MAX)
		else $error("byte position past largest frame");

	a_tally_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tally_q <= TALLY_MAX)
		else $error("alert tally past limit");

endmodule

// ----- rtl/mtfg_out_stage.sv -----
module mtfg_out_stage
	import mtfg_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  res_item_t res,
	output logic      slot_free,
	output logic      valid_s2,
	input  logic      out_ready,
	output res_item_t res_s2
);

	// slot can take a new item this cycle if empty or draining
	assign slot_free = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (push) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res_s2 <= res;
		end
	end

endmodule

// ----- rtl/modbus_tcp_frame_guard_top.sv -----
// Modbus TCP MBAP deframer and write-alert guard.
//
// Input channel (in_valid/in_ready): one stream byte per item, with
// segment_end marking the last byte of a received buffer. Frames may span
// buffers. Output channel (out_valid/out_ready): at most one result item per
// input byte, produced when a frame completes, a header or function code
// check fails, or the byte ends a buffer. Config: cfg_we/cfg_wdata write
// max_length; the user must write it only while idle; the block trusts this.
//
// Throughput: one byte per cycle while out_ready is high. Each byte passes
// an input register, then the header parser (byte position counter and
// captured header fields) decides it combinationally into the result
// register, which drives out_valid and the result outputs.
// Stall: when out_ready is low with a result waiting, the parser holds and
// the input register fills; in_ready then drops until the result is taken.
// Bytes that raise no result still advance while the result register is
// empty or draining.
// Reset (arst_n low): position returns to the header start, the tally and
// halt flag clear, max_length returns to 254. After any error one result is
// sent and all further bytes are taken and dropped until reset.
module modbus_tcp_frame_guard_top
	import mtfg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        segment_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        frame_valid,
	output logic [1:0]  error_code,
	output logic [15:0] xact_id,
	output logic [7:0]  unit_id,
	output logic [7:0]  fn_code,
	output logic [7:0]  pdu_length,
	output logic        is_write,
	output logic        segment_done,
	output logic [15:0] segment_alerts
);

	in_item_t  in_item;
	in_item_t  item_s1;
	logic      valid_s1;
	logic      advance;
	logic      slot_free;
	logic      res_emit;
	res_item_t res;
	res_item_t res_s2;

	assign in_item.data_byte   = data_byte;
	assign in_item.segment_end = segment_end;

	// a byte leaves the input register once the result slot can take it
	assign advance = valid_s1 && slot_free;

	mtfg_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	mtfg_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.item_valid (advance),
		.item       (item_s1),
		.res_emit   (res_emit),
		.res        (res)
	);

	mtfg_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance && res_emit),
		.res       (res),
		.slot_free (slot_free),
		.valid_s2  (out_valid),
		.out_ready (out_ready),
		.res_s2    (res_s2)
	);

	assign frame_valid    = res_s2.frame_valid;
	assign error_code     = res_s2.error_code;
	assign xact_id        = res_s2.xact_id;
	assign unit_id        = res_s2.unit_id;
	assign fn_code        = res_s2.fn_code;
	assign pdu_length     = res_s2.pdu_length;
	assign is_write       = res_s2.is_write;
	assign segment_done   = res_s2.segment_done;
	assign segment_alerts = res_s2.segment_alerts;

endmodule

// ----- tb/modbus_tcp_frame_guard_top_test.sv -----
module modbus_tcp_frame_guard_top_test
	import mtfg_pkg::*;
();

	// ------------------------------------------------------------------
	// Run constants
	// ------------------------------------------------------------------
	localparam int CYCLE_LIMIT  = 200_000;
	localparam int DRAIN_CYCLES = 8;
	localparam int END_CYCLES   = 16;
	localparam int LONG_HOLD    = 400;       // receiver hold-off, in cycles
	localparam int PHASE_ITEMS  = 300;       // four idle modes, ~1200 bytes total
	localparam int PRESS_ITEMS  = 150;
	localparam int NOISE_BYTES  = 40;        // fed after the halt, all dropped

	// frame layout as seen by the checker's own model
	localparam logic [15:0] TAIL_OFFSET = 16'd5;   // last byte at 5 + length
	localparam logic [7:0]  ADU_CAP     = 8'd254;  // length field ceiling
	localparam logic [15:0] ALERT_CAP   = 16'hFFFF;

	// read codes and one code the guard must refuse
	localparam logic [7:0] FC_READ_COILS    = 8'd1;
	localparam logic [7:0] FC_READ_DISCRETE = 8'd2;
	localparam logic [7:0] FC_READ_HOLDING  = 8'd3;
	localparam logic [7:0] FC_READ_INPUT    = 8'd4;
	localparam logic [7:0] FC_BAD           = 8'd7;

	// reads first, writes at 4..8
	localparam logic [7:0] FC_SET [9] = '{FC_READ_COILS, FC_READ_DISCRETE,
		FC_READ_HOLDING, FC_READ_INPUT, FC_WRITE_COIL, FC_WRITE_REG,
		FC_WRITE_COILS, FC_WRITE_REGS, FC_RW_REGS};

	// One stream byte plus, where it is obvious, the result it must raise
	typedef struct packed {
		logic [7:0] b;
		logic       se;
		logic       typed;
		res_item_t  want;
	} stim_row_t;

	localparam res_item_t NO_RESULT = '0;

	// Directed stream, default max_length (254):
	//  frame A: all-ones ids, shortest length, write code, buffer end on its
	//           first byte (mid-header) and on its last byte
	//  frame B: all-zero ids, shortest length, read code, no buffer end
	//  frame C: two-byte PDU with read/write-multiple code
	localparam stim_row_t DIR_ROWS [25] = '{
		'{8'hFF, 1'b1, 1'b1,
			'{1'b0, ERR_NONE, 16'h0000, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 16'd0}},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h02, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{FC_WRITE_REGS, 1'b1, 1'b1,
			'{1'b1, ERR_NONE, 16'hFFFF, 8'hFF, FC_WRITE_REGS, 8'd1, 1'b1, 1'b1, 16'd1}},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h02, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{FC_READ_COILS, 1'b0, 1'b1,
			'{1'b1, ERR_NONE, 16'h0000, 8'h00, FC_READ_COILS, 8'd1, 1'b0, 1'b0, 16'd0}},
		'{8'h5A, 1'b0, 1'b0, NO_RESULT},
		'{8'hA5, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h03, 1'b0, 1'b0, NO_RESULT},
		'{8'h80, 1'b0, 1'b0, NO_RESULT},
		'{FC_RW_REGS, 1'b0, 1'b0, NO_RESULT},
		'{8'h7E, 1'b1, 1'b0, NO_RESULT}
	};

	// The block halts for good on its first error, so each run ends on one
	// fault picked at random. Alert count is zero here: the phase before
	// always closes its buffer on a frame boundary.
	typedef enum int {
		FLT_PROTOCOL,   // nonzero protocol id
		FLT_LEN_FIELD,  // length 0x0100, high byte set
		FLT_LEN_CFG,    // length 2 with max_length 0 or 1
		FLT_FUNCTION    // unknown function code, on a buffer end
	} fault_t;

	localparam int FAULT_FIRST [4] = '{0, 7, 14, 21};
	localparam int FAULT_COUNT [4] = '{7, 7, 7, 10};

	localparam stim_row_t FAULT_ROWS [31] = '{
		'{8'h12, 1'b0, 1'b0, NO_RESULT},
		'{8'h34, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h01, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h06, 1'b0, 1'b0, NO_RESULT},
		'{8'h07, 1'b0, 1'b1,
			'{1'b0, ERR_PROTOCOL, 16'h1234, 8'h07, 8'h00, 8'h00, 1'b0, 1'b0, 16'd0}},
		'{8'hBE, 1'b0, 1'b0, NO_RESULT},
		'{8'hEF, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h01, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h22, 1'b0, 1'b1,
			'{1'b0, ERR_LENGTH, 16'hBEEF, 8'h22, 8'h00, 8'h00, 1'b0, 1'b0, 16'd0}},
		'{8'hAB, 1'b0, 1'b0, NO_RESULT},
		'{8'hCD, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h02, 1'b0, 1'b0, NO_RESULT},
		'{8'h11, 1'b0, 1'b1,
			'{1'b0, ERR_LENGTH, 16'hABCD, 8'h11, 8'h00, 8'h00, 1'b0, 1'b0, 16'd0}},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h07, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h04, 1'b0, 1'b0, NO_RESULT},
		'{8'h2A, 1'b0, 1'b0, NO_RESULT},
		'{FC_BAD, 1'b0, 1'b0, NO_RESULT},
		'{8'h55, 1'b0, 1'b0, NO_RESULT},
		'{8'hAA, 1'b1, 1'b1,
			'{1'b0, ERR_FUNCTION, 16'h0007, 8'h2A, FC_BAD, 8'd3, 1'b0, 1'b1, 16'd0}}
	};

	// ------------------------------------------------------------------
	// DUT signals; every input known from time zero
	// ------------------------------------------------------------------
	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_wdata = 8'h00;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        segment_end = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        frame_valid;
	logic [1:0]  error_code;
	logic [15:0] xact_id;
	logic [7:0]  unit_id;
	logic [7:0]  fn_code;
	logic [7:0]  pdu_length;
	logic        is_write;
	logic        segment_done;
	logic [15:0] segment_alerts;

	modbus_tcp_frame_guard_top dut (.*);

	// ------------------------------------------------------------------
	// Checker state
	// ------------------------------------------------------------------
	// Deframer model: position, captured header, halt flag, alert tally
	logic [8:0]  mb_pos;
	logic [15:0] mb_tid;
	logic [15:0] mb_proto;
	logic [15:0] mb_len;
	logic [7:0]  mb_unit;
	logic [7:0]  mb_func;
	logic        mb_halted;
	logic [15:0] mb_tally;
	logic [7:0]  mb_max_len;

	res_item_t pending_results [$];   // results owed by the block, oldest first

	int tx_idle_pct  = 0;   // chance per slot that the sender sits out
	int rx_stall_pct = 0;   // chance per cycle that out_ready is low
	bit long_hold_req = 1'b0;
	int hold_left = 0;

	int cycle_count = 0;
	int n_fail = 0;
	int n_items = 0;
	int n_frames = 0;
	int n_writes = 0;
	int n_buffer_ends = 0;
	int n_held_off = 0;
	logic [15:0] peak_alerts = '0;
	err_t halt_code = ERR_NONE;

	// ------------------------------------------------------------------
	// Clock, watchdog
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Run stopped at the cycle limit, %0d results still owed",
			pending_results.size());
		$display("Regression FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// Deframer model
	// ------------------------------------------------------------------
	function automatic bit fc_known(input logic [7:0] fc);
		case (fc)
			FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT,
			FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_COILS, FC_WRITE_REGS,
			FC_RW_REGS: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic bit fc_writes(input logic [7:0] fc);
		case (fc)
			FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_COILS, FC_WRITE_REGS,
			FC_RW_REGS: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// max_length above the ADU ceiling acts as the ceiling
	function automatic logic [7:0] length_ceiling();
		return (mb_max_len > ADU_CAP) ? ADU_CAP : mb_max_len;
	endfunction

	// Advance the model by one stream byte; returns 1 when a result is owed
	function automatic bit deframe_byte(input logic [7:0] b, input logic se,
			output res_item_t r);
		logic [8:0] p;
		logic [7:0] lim;
		err_t       fault;
		bit         done;
		r = '0;
		fault = ERR_NONE;
		done = 1'b0;
		if (mb_halted)
			return 1'b0;
		p = mb_pos;
		lim = length_ceiling();
		case (p)
			9'd0: begin
				mb_tid = {b, 8'h00};
				mb_func = 8'h00;
			end
			9'd1: mb_tid[7:0] = b;
			9'd2: mb_proto = {b, 8'h00};
			9'd3: mb_proto[7:0] = b;
			9'd4: mb_len = {b, 8'h00};
			9'd5: mb_len[7:0] = b;
			9'd6: begin
				// header complete: protocol id, then length window
				mb_unit = b;
				if (mb_proto != 16'h0000)
					fault = ERR_PROTOCOL;
				else if (mb_len < 16'd2 || mb_len > 16'(lim))
					fault = ERR_LENGTH;
			end
			default: begin
				if (p == 9'd7)
					mb_func = b;
				if (16'(p) == TAIL_OFFSET + mb_len) begin
					if (fc_known(mb_func))
						done = 1'b1;
					else
						fault = ERR_FUNCTION;
				end
			end
		endcase

		if (fault != ERR_NONE) begin
			mb_halted = 1'b1;
			r.xact_id = mb_tid;
			r.unit_id = mb_unit;
			if (fault == ERR_FUNCTION) begin
				r.fn_code = mb_func;
				r.pdu_length = mb_len[7:0] - 8'd1;
			end
		end else if (done) begin
			r.xact_id = mb_tid;
			r.unit_id = mb_unit;
			r.fn_code = mb_func;
			r.pdu_length = mb_len[7:0] - 8'd1;
			if (fc_writes(mb_func)) begin
				r.is_write = 1'b1;
				if (mb_tally != ALERT_CAP)
					mb_tally = mb_tally + 16'd1;
			end
			mb_pos = '0;
		end else begin
			mb_pos = p + 9'd1;
		end

		if (!done && fault == ERR_NONE && !se)
			return 1'b0;
		r.frame_valid = done;
		r.error_code = fault;
		r.segment_done = se;
		r.segment_alerts = mb_tally;
		// buffer end reports the tally, then clears it
		if (se && fault == ERR_NONE)
			mb_tally = '0;
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers; all drive at the falling edge and return there
	// ------------------------------------------------------------------
	// Offer one byte and hold it until taken. A typed row supplies its own
	// result; the model still runs so its state stays in step.
	task automatic feed_byte(input logic [7:0] b, input logic se,
			input logic typed, input res_item_t want);
		res_item_t calc;
		bit owed;
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		segment_end <= se;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		n_items++;
		owed = deframe_byte(b, se, calc);
		if (typed)
			pending_results.push_back(want);
		else if (owed)
			pending_results.push_back(calc);
		@(negedge clk);
	endtask

	// Stop offering, let every owed result out, then let the pipe empty
	task automatic quiesce();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_max_len(input logic [7:0] v);
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		mb_max_len = v;
	endtask

	function automatic bit pick_end(input int odds);
		return (odds != 0) && ($urandom_range(odds - 1) == 0);
	endfunction

	// mostly short frames, now and then anything up to the limit
	function automatic logic [15:0] pick_len(input logic [7:0] lim);
		int roll;
		roll = $urandom_range(39);
		if (roll == 0)
			return 16'(lim);
		if (roll < 4)
			return 16'($urandom_range(lim, 2));
		return 16'($urandom_range((lim < 8'd12) ? lim : 8'd12, 2));
	endfunction

	// Well-formed frame, random ids and payload, buffer ends sprinkled in
	task automatic send_frame(input logic [15:0] len, input logic [7:0] fc,
			input int end_odds, input bit end_on_last);
		logic [7:0]  bytes [$];
		logic [15:0] tid;
		tid = 16'($urandom);
		bytes = {tid[15:8], tid[7:0], 8'h00, 8'h00, len[15:8], len[7:0],
			8'($urandom), fc};
		for (int i = 2; i < len; i++)
			bytes.push_back(8'($urandom));
		foreach (bytes[i])
			feed_byte(bytes[i],
				pick_end(end_odds) || (end_on_last && i == bytes.size() - 1),
				1'b0, NO_RESULT);
	endtask

	// One traffic phase: new max_length while idle, new idle mode, the first
	// frame at the longest accepted length, then random frames.
	task automatic run_traffic(input int tx, input int rx, input logic [7:0] max_len,
			input int budget, input int end_odds, input bit hold);
		int stop_at;
		logic [7:0] lim;
		quiesce();
		write_max_len(max_len);
		tx_idle_pct = tx;
		rx_stall_pct = rx;
		long_hold_req = hold;
		lim = length_ceiling();
		stop_at = n_items + budget;
		send_frame(16'(lim), FC_SET[$urandom_range(8)], end_odds, 1'b0);
		while (n_items < stop_at)
			send_frame(pick_len(lim), FC_SET[$urandom_range(8)], end_odds, 1'b0);
	endtask

	// ------------------------------------------------------------------
	// Receiver: random stalls, plus one long hold-off on request so the
	// block backs up and drops in_ready while the sender keeps offering
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (long_hold_req) begin
			long_hold_req = 1'b0;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Result checker
	// ------------------------------------------------------------------
	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			n_fail++;
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		res_item_t seen;
		res_item_t want;
		if (arst_n && in_valid && !in_ready)
			n_held_off++;
		if (arst_n && out_valid && out_ready) begin
			seen.frame_valid = frame_valid;
			seen.error_code = err_t'(error_code);
			seen.xact_id = xact_id;
			seen.unit_id = unit_id;
			seen.fn_code = fn_code;
			seen.pdu_length = pdu_length;
			seen.is_write = is_write;
			seen.segment_done = segment_done;
			seen.segment_alerts = segment_alerts;
			if (pending_results.size() == 0) begin
				n_fail++;
				$display("%0t: result with none expected, got 0x%0h", $time, seen);
			end else begin
				want = pending_results.pop_front();
				check_field("frame_valid", 16'(want.frame_valid), 16'(seen.frame_valid));
				check_field("error_code", 16'(want.error_code), 16'(seen.error_code));
				check_field("xact_id", want.xact_id, seen.xact_id);
				check_field("unit_id", 16'(want.unit_id), 16'(seen.unit_id));
				check_field("fn_code", 16'(want.fn_code), 16'(seen.fn_code));
				check_field("pdu_length", 16'(want.pdu_length), 16'(seen.pdu_length));
				check_field("is_write", 16'(want.is_write), 16'(seen.is_write));
				check_field("segment_done", 16'(want.segment_done), 16'(seen.segment_done));
				check_field("segment_alerts", want.segment_alerts, seen.segment_alerts);
			end
			if (seen.frame_valid)
				n_frames++;
			if (seen.is_write)
				n_writes++;
			if (seen.segment_done)
				n_buffer_ends++;
			if (seen.segment_alerts > peak_alerts)
				peak_alerts = seen.segment_alerts;
			if (seen.error_code != ERR_NONE)
				halt_code = seen.error_code;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		fault_t fault;
		mb_pos = '0;
		mb_tid = '0;
		mb_proto = '0;
		mb_len = '0;
		mb_unit = '0;
		mb_func = '0;
		mb_halted = 1'b0;
		mb_tally = '0;
		mb_max_len = MAX_LEN_RESET;

		// single reset at the start of the run
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed rows at the reset max_length, no idling
		foreach (DIR_ROWS[i])
			feed_byte(DIR_ROWS[i].b, DIR_ROWS[i].se, DIR_ROWS[i].typed, DIR_ROWS[i].want);

		// random traffic, one idle mode and one max_length each:
		// top code (acts as 254), the minimum, a random middle value, 254
		run_traffic(0, 0, 8'hFF, PHASE_ITEMS, 6, 1'b0);
		run_traffic(88, 0, 8'd2, PHASE_ITEMS, 6, 1'b0);
		run_traffic(0, 88, 8'($urandom_range(253, 3)), PHASE_ITEMS, 6, 1'b0);
		run_traffic(10, 10, MAX_LEN_RESET, PHASE_ITEMS, 6, 1'b0);

		// back-pressure: receiver holds off while buffer ends come often
		run_traffic(0, 0, MAX_LEN_RESET, PRESS_ITEMS, 2, 1'b1);

		// one short frame that closes the buffer on its last byte, so the
		// tally is zero again before the fault
		quiesce();
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		send_frame(16'd2, FC_SET[$urandom_range(8)], 0, 1'b1);

		// terminal fault, then bytes the halted block must swallow silently
		quiesce();
		fault = fault_t'($urandom_range(3));
		if (fault == FLT_LEN_CFG)
			write_max_len(8'($urandom_range(1)));
		for (int i = FAULT_FIRST[fault]; i < FAULT_FIRST[fault] + FAULT_COUNT[fault]; i++)
			feed_byte(FAULT_ROWS[i].b, FAULT_ROWS[i].se, FAULT_ROWS[i].typed,
				FAULT_ROWS[i].want);
		tx_idle_pct = 10;
		rx_stall_pct = 10;
		repeat (NOISE_BYTES)
			feed_byte(8'($urandom), 1'($urandom), 1'b0, NO_RESULT);

		quiesce();
		repeat (END_CYCLES) @(negedge clk);
		if (pending_results.size() != 0) begin
			n_fail++;
			$display("%0t: %0d results never arrived", $time, pending_results.size());
		end

		$display("Covered %0d bytes: %0d good frames, %0d writes, %0d buffer ends, peak tally %0d",
			n_items, n_frames, n_writes, n_buffer_ends, peak_alerts);
		$display("Input held off %0d cycles; halted on %s (%s)",
			n_held_off, halt_code.name(), fault.name());
		if (n_fail == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches", n_fail);
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ----- modbus_tcp_frame_guard_top.f -----
rtl/mtfg_pkg.sv
rtl/mtfg_in_stage.sv
rtl/mtfg_parser.sv
rtl/mtfg_out_stage.sv
rtl/modbus_tcp_frame_guard_top.sv
tb/modbus_tcp_frame_guard_top_test.sv
